### hdl/e2h_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// equatorial to horizontal converter. Depends on nothing.
package e2h_pkg;

  // Angles: 1/256 arcsecond. A full circle is 360 * 3600 * 256.
  localparam int FULL_CIRCLE  = 331776000;
  localparam int HALF_CIRCLE  = 165888000;
  localparam int Q30_ONE      = 1073741824;
  localparam int CORDIC_K_INV = 652032874;
  localparam int ATAN_ENTRIES = 40;

  // Phase conversion: a * 2^32 / FULL_CIRCLE == a * 2^17 / PHASE_DIV.
  // RECIP_DIV is floor(2^45 / PHASE_DIV).
  localparam int          PHASE_DIV = 10125;
  localparam logic [31:0] RECIP_DIV = 32'd3474999712;

  // Datapath widths
  localparam int ROT_W      = 34;  // rotation x, y, z
  localparam int VEC_W      = 36;  // vectoring x, y
  localparam int VZ_W       = 34;  // vectoring angle accumulator
  localparam int SQRT_STEPS = 31;  // root bits of a value up to 2^60

  // Register map (address bit 2 selects)
  localparam logic REG_SIN_LAT = 1'b0;
  localparam logic REG_COS_LAT = 1'b1;
  localparam logic signed [31:0] SIN_LAT_RESET = 32'sd741199459;
  localparam logic signed [31:0] COS_LAT_RESET = 32'sd776881501;

  typedef struct packed {
    logic        [24:0] right_ascension;
    logic signed [27:0] declination;
    logic        [24:0] sidereal_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [28:0] azimuth;
    logic        [27:0] zenith_distance;
    logic        [28:0] parallactic_angle;
  } out_beat_t;

  // Operands that ride alongside the square root
  typedef struct packed {
    logic signed [31:0] cz;
    logic signed [35:0] yaz;
    logic signed [35:0] xaz;
    logic signed [35:0] sp;
    logic signed [35:0] cp;
  } side_t;

  // Rounded arctangent of 2^-i in phase units (2^32 per turn)
  function automatic logic [29:0] atan_phase(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/e2h_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; the payload type is set where it is instantiated.
interface e2h_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/e2h_cordic_rot.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a 32-bit phase, Q30.
// Depends on e2h_pkg.
module e2h_cordic_rot
  import e2h_pkg::*;
#(
  parameter int STAGES = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             phase,
  output logic signed [ROT_W-1:0] sin_o,
  output logic signed [ROT_W-1:0] cos_o
);

  localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

  logic signed [ROT_W-1:0] x_r [N+1];
  logic signed [ROT_W-1:0] y_r [N+1];
  logic signed [ROT_W-1:0] z_r [N+1];
  logic        [1:0]       q_r [N+1];
  logic signed [ROT_W-1:0] sin_r, cos_r;
  logic [1:0]  quad;
  logic [31:0] resid;
  logic [31:0] rounded;

  // fold to the nearest quadrant
  always_comb begin
    rounded = phase + 32'h2000_0000;
    quad    = rounded[31:30];
    resid   = phase - {quad, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= ROT_W'(CORDIC_K_INV);
      y_r[0] <= '0;
      z_r[0] <= ROT_W'($signed(resid));
      q_r[0] <= quad;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][ROT_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ROT_W'(atan_phase(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ROT_W'(atan_phase(i));
        end
      end
    end
  end

  // unfold the quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[N])
        2'd0: begin
          cos_r <= x_r[N];
          sin_r <= y_r[N];
        end
        2'd1: begin
          cos_r <= -y_r[N];
          sin_r <= x_r[N];
        end
        2'd2: begin
          cos_r <= -x_r[N];
          sin_r <= -y_r[N];
        end
        default: begin
          cos_r <= y_r[N];
          sin_r <= -x_r[N];
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### hdl/e2h_cordic_vec.sv
// Pipelined vectoring-mode CORDIC: atan2(y, x) as a phase, 2^32 per turn.
// Depends on e2h_pkg.
module e2h_cordic_vec
  import e2h_pkg::*;
#(
  parameter int STAGES = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VEC_W-1:0] y_i,
  input  logic signed [VEC_W-1:0] x_i,
  output logic signed [VZ_W-1:0]  angle_o
);

  localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

  logic signed [VEC_W-1:0] x_r [N+1];
  logic signed [VEC_W-1:0] y_r [N+1];
  logic signed [VZ_W-1:0]  z_r [N+1];
  logic                    zero_r [N+1];
  logic signed [VEC_W-1:0] fx, fy;
  logic signed [VZ_W-1:0]  fz;

  // left half-plane: rotate by a quarter turn first
  always_comb begin
    fx = x_i;
    fy = y_i;
    fz = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        fx = y_i;
        fy = -x_i;
        fz = VZ_W'(Q30_ONE);
      end else begin
        fx = -y_i;
        fy = x_i;
        fz = -VZ_W'(Q30_ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= fx;
      y_r[0]    <= fy;
      z_r[0]    <= fz;
      zero_r[0] <= (x_i == 0) && (y_i == 0);
    end
  end

  // drive y towards zero
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][VEC_W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + VZ_W'(atan_phase(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - VZ_W'(atan_phase(i));
        end
      end
    end
  end

  // a zero vector gives angle zero
  assign angle_o = zero_r[N] ? '0 : z_r[N];

endmodule

### hdl/equatorial_to_horizontal_coords.sv
// Top level of the equatorial to horizontal converter: phase conversion,
// spherical products, square root, output scaling and the APB registers.
// Depends on e2h_pkg, e2h_stream_if, e2h_cordic_rot and e2h_cordic_vec.
//
//   port      dir  beat contents
//   in_ch     in   right_ascension, declination, sidereal_time
//   out_ch    out  azimuth, zenith_distance, parallactic_angle
//   psel..    in   APB register writes/reads (sin_latitude, cos_latitude)
//
// One beat in and one beat out per cycle when not stalled.
// The depth comes from two CORDIC chains in series, N = min(CORDIC_STAGES, 40),
// plus the 31-step square root.
// rst_n clears all valid bits and loads the latitude registers.
// A stalled output freezes the whole pipeline; in_ch.ready falls with it.
module equatorial_to_horizontal_coords
  import e2h_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  e2h_stream_if.sink          in_ch,
  e2h_stream_if.source        out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NST     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int ROT_LAT = NST + 2;
  localparam int VEC_LAT = NST + 1;
  localparam int LAT     = 6 + ROT_LAT + 6 + SQRT_STEPS + VEC_LAT + 2;

  localparam logic signed [35:0] Q30_P  = 36'sd1073741824;
  localparam logic signed [31:0] HALF_P = 32'sd165888000;
  localparam logic signed [31:0] FULL_P = 32'sd331776000;

  function automatic logic signed [35:0] qmul(input logic signed [35:0] a,
                                              input logic signed [35:0] b);
    logic signed [71:0] p;
    p = 72'(a) * 72'(b);
    return p[65:30];
  endfunction

  // ---------------------------------------------------------------- registers
  logic signed [31:0] sin_lat_r, cos_lat_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_lat_r <= SIN_LAT_RESET;
      cos_lat_r <= COS_LAT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SIN_LAT: sin_lat_r <= pwdata;
        REG_COS_LAT: cos_lat_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIN_LAT: prdata = sin_lat_r;
      REG_COS_LAT: prdata = cos_lat_r;
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic v_r [LAT];
  logic en;

  assign en          = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  // ---------------------------------------------------------------- hour angle
  logic signed [25:0] diff;
  logic signed [29:0] diff_x, ha_raw;
  logic signed [29:0] ha1_r;
  logic signed [27:0] dec1_r;

  always_comb begin
    diff   = $signed({1'b0, in_ch.payload.sidereal_time})
           - $signed({1'b0, in_ch.payload.right_ascension});
    diff_x = 30'(diff);
    ha_raw = (diff_x <<< 4) - diff_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha1_r  <= ha_raw;
      dec1_r <= in_ch.payload.declination;
    end
  end

  // reduce both angles into one turn
  logic signed [30:0] h, hp1, hp2, hm1, hsel;
  logic signed [29:0] dsel;
  logic [28:0]        m2_r [2];

  always_comb begin
    h    = 31'(ha1_r);
    hp1  = h + 31'(FULL_P);
    hp2  = hp1 + 31'(FULL_P);
    hm1  = h - 31'(FULL_P);
    if (h < 0)                hsel = (hp1 < 0) ? hp2 : hp1;
    else if (h >= 31'(FULL_P)) hsel = hm1;
    else                      hsel = h;
    dsel = (dec1_r < 0) ? 30'(dec1_r) + 30'(FULL_P) : 30'(dec1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r[0] <= hsel[28:0];
      m2_r[1] <= dsel[28:0];
    end
  end

  // phase = floor(m * 2^17 / 10125): reciprocal, then one correction
  logic [60:0] p3_r  [2];
  logic [28:0] m3_r  [2];
  logic [31:0] q4_r  [2];
  logic [28:0] m4_r  [2];
  logic [45:0] qm5_r [2];
  logic [31:0] q5_r  [2];
  logic [28:0] m5_r  [2];
  logic [31:0] ph6_r [2];
  logic [45:0] rem6  [2];

  always_comb begin
    for (int c = 0; c < 2; c++) rem6[c] = {m5_r[c], 17'd0} - qm5_r[c];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        p3_r[c]  <= 61'(m2_r[c]) * 61'(RECIP_DIV);
        m3_r[c]  <= m2_r[c];
        q4_r[c]  <= p3_r[c][59:28];
        m4_r[c]  <= m3_r[c];
        qm5_r[c] <= 46'(q4_r[c]) * 46'(PHASE_DIV);
        q5_r[c]  <= q4_r[c];
        m5_r[c]  <= m4_r[c];
        ph6_r[c] <= q5_r[c] + 32'(rem6[c] >= 46'(PHASE_DIV));
      end
    end
  end

  // ---------------------------------------------------------------- sin/cos
  logic signed [ROT_W-1:0] sin_t, cos_t, sin_d, cos_d;

  e2h_cordic_rot #(.STAGES(NST)) u_rot_ha (
    .clk   (clk),
    .en    (en),
    .phase (ph6_r[0]),
    .sin_o (sin_t),
    .cos_o (cos_t)
  );

  e2h_cordic_rot #(.STAGES(NST)) u_rot_dec (
    .clk   (clk),
    .en    (en),
    .phase (ph6_r[1]),
    .sin_o (sin_d),
    .cos_o (cos_d)
  );

  // ---------------------------------------------------------------- products
  logic signed [35:0] a1_r, b1_r, yaz1_r, d1_r, e1_r, sp1_r, ct1_r;
  logic signed [35:0] act2_r, dct2_r, ect2_r, b2_r, d2_r, e2_r, yaz2_r, sp2_r;
  logic signed [35:0] cz3_r, xaz3_r, cp3_r, yaz3_r, sp3_r;
  logic signed [31:0] cz_clamp;
  side_t              side4_r, side5_r, side6_r;
  logic signed [63:0] czsq;
  logic [60:0]        sq5_r, rest6_r;

  always_comb begin
    if (cz3_r > Q30_P)       cz_clamp = 32'(Q30_P);
    else if (cz3_r < -Q30_P) cz_clamp = 32'(-Q30_P);
    else                     cz_clamp = 32'(cz3_r);
    czsq = 64'(side4_r.cz) * 64'(side4_r.cz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Q30 pair products
      a1_r   <= qmul(36'(cos_lat_r), 36'(cos_d));
      b1_r   <= qmul(36'(sin_lat_r), 36'(sin_d));
      yaz1_r <= qmul(36'(cos_d), 36'(sin_t));
      d1_r   <= qmul(36'(cos_d), 36'(sin_lat_r));
      e1_r   <= qmul(36'(cos_lat_r), 36'(sin_d));
      sp1_r  <= qmul(36'(sin_t), 36'(cos_lat_r));
      ct1_r  <= 36'(cos_t);
      // third factor: cos of hour angle
      act2_r <= qmul(a1_r, ct1_r);
      dct2_r <= qmul(d1_r, ct1_r);
      ect2_r <= qmul(e1_r, ct1_r);
      b2_r   <= b1_r;
      d2_r   <= d1_r;
      e2_r   <= e1_r;
      yaz2_r <= yaz1_r;
      sp2_r  <= sp1_r;
      // sums
      cz3_r  <= act2_r + b2_r;
      xaz3_r <= dct2_r - e2_r;
      cp3_r  <= d2_r - ect2_r;
      yaz3_r <= yaz2_r;
      sp3_r  <= sp2_r;
      // clamp zenith-distance cosine
      side4_r.cz  <= cz_clamp;
      side4_r.yaz <= yaz3_r;
      side4_r.xaz <= xaz3_r;
      side4_r.sp  <= sp3_r;
      side4_r.cp  <= cp3_r;
      // 1 - cz^2 in Q60
      sq5_r   <= czsq[60:0];
      side5_r <= side4_r;
      rest6_r <= (61'd1 << 60) - sq5_r;
      side6_r <= side5_r;
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic [62:0] sq_rem_r  [SQRT_STEPS];
  logic [30:0] sq_root_r [SQRT_STEPS];
  side_t       sq_side_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - j;
    logic [62:0] rem_in, trial;
    logic [30:0] root_in;
    side_t       side_in;

    if (j == 0) begin : g_first
      assign rem_in  = {2'b00, rest6_r};
      assign root_in = '0;
      assign side_in = side6_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign side_in = sq_side_r[j-1];
    end

    // (2r + 2^k) * 2^k against the remainder
    assign trial = ({31'd0, root_in, 1'b0} + (63'd1 << K)) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[j] <= side_in;
        if (rem_in >= trial) begin
          sq_rem_r[j]  <= rem_in - trial;
          sq_root_r[j] <= root_in | (31'd1 << K);
        end else begin
          sq_rem_r[j]  <= rem_in;
          sq_root_r[j] <= root_in;
        end
      end
    end
  end

  // ---------------------------------------------------------------- atan2
  side_t                  side_s;
  logic signed [VZ_W-1:0] z_zd, z_az, z_pa;

  assign side_s = sq_side_r[SQRT_STEPS-1];

  e2h_cordic_vec #(.STAGES(NST)) u_vec_zd (
    .clk     (clk),
    .en      (en),
    .y_i     ($signed(VEC_W'(sq_root_r[SQRT_STEPS-1]))),
    .x_i     (VEC_W'(side_s.cz)),
    .angle_o (z_zd)
  );

  e2h_cordic_vec #(.STAGES(NST)) u_vec_az (
    .clk     (clk),
    .en      (en),
    .y_i     (side_s.yaz),
    .x_i     (side_s.xaz),
    .angle_o (z_az)
  );

  e2h_cordic_vec #(.STAGES(NST)) u_vec_pa (
    .clk     (clk),
    .en      (en),
    .y_i     (side_s.sp),
    .x_i     (side_s.cp),
    .angle_o (z_pa)
  );

  // ---------------------------------------------------------------- scaling
  logic signed [63:0] pz_zd_r, pz_az_r, pz_pa_r;
  logic signed [63:0] r_zd, r_az, r_pa;
  logic signed [31:0] u_zd, u_az, u_pa;
  out_beat_t          out_r;

  always_comb begin
    r_zd = (pz_zd_r + 64'sd2147483648) >>> 32;
    r_az = (pz_az_r + 64'sd2147483648) >>> 32;
    r_pa = (pz_pa_r + 64'sd2147483648) >>> 32;
    u_zd = (r_zd > 64'(HALF_P)) ? HALF_P : (r_zd < -64'(HALF_P)) ? -HALF_P : 32'(r_zd);
    u_az = (r_az > 64'(HALF_P)) ? HALF_P : (r_az < -64'(HALF_P)) ? -HALF_P : 32'(r_az);
    u_pa = (r_pa > 64'(HALF_P)) ? HALF_P : (r_pa < -64'(HALF_P)) ? -HALF_P : 32'(r_pa);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pz_zd_r <= 64'(z_zd) * 64'(FULL_P);
      pz_az_r <= 64'(z_az) * 64'(FULL_P);
      pz_pa_r <= 64'(z_pa) * 64'(FULL_P);
      out_r.azimuth           <= u_az[28:0];
      out_r.zenith_distance   <= (u_zd < 0) ? '0 : u_zd[27:0];
      out_r.parallactic_angle <= (u_pa < 0) ? 29'(u_pa + FULL_P) : u_pa[28:0];
    end
  end

  assign out_ch.valid   = v_r[LAT-1];
  assign out_ch.payload = out_r;

  // ---------------------------------------------------------------- checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid straight after reset");

  a_zd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.payload.zenith_distance <= 28'(HALF_P)))
    else $error("zenith distance beyond half turn");

  a_pa_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.payload.parallactic_angle <= 29'(FULL_P)))
    else $error("parallactic angle beyond full turn");

endmodule
